>>> sv/lcat_pkg.sv
`timescale 1ns / 1ps

package lcat_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int IP_W    = 32;
    localparam int PORT_W  = 16;
    localparam int TIME_W  = 32;
    localparam int SLOTS_W = 5;
    localparam int SLOT_W  = 4;
    localparam int OUTC_W  = 2;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 56;

    localparam logic [SLOTS_W-1:0] ACTIVE_SLOTS_RESET = SLOTS_W'(16);
    localparam logic REG_ACTIVE_SLOTS = 1'b0;

    localparam logic [OUTC_W-1:0] OUTC_REFRESH = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_FILL    = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_EVICT   = 2'd2;

    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] tstamp;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic older;
    } cmp_res_t;

endpackage

>>> sv/lcat_mem.sv
`timescale 1ns / 1ps

module lcat_mem (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [lcat_pkg::IDX_W-1:0] waddr,
    input  lcat_pkg::entry_t          wdata,
    input  logic [lcat_pkg::IDX_W-1:0] raddr,
    output lcat_pkg::entry_t          rdata
);

    lcat_pkg::entry_t mem [lcat_pkg::TABLE_DEPTH];
    lcat_pkg::entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/lcat_cmp.sv
`timescale 1ns / 1ps

module lcat_cmp (
    input  lcat_pkg::entry_t             entry,
    input  logic [lcat_pkg::IP_W-1:0]    key_ip,
    input  logic [lcat_pkg::PORT_W-1:0]  key_port,
    input  logic                         have_old,
    input  logic [lcat_pkg::TIME_W-1:0]  old_time,
    output lcat_pkg::cmp_res_t           res
);

    always_comb begin
        res.hit   = (entry.ip == key_ip) && (entry.port == key_port);
        res.older = !have_old || (entry.tstamp < old_time);
    end

endmodule

>>> sv/lru_client_address_table_unit.sv
`timescale 1ns / 1ps
// Each input beat starts a scan of n table entries, n = active slots clamped to 1..16.
// Beats are taken one at a time; one table entry per cycle goes through the shared compare
// unit, then compare drain, decision, write-back (held while an earlier result waits on m_tready) and idle.
// A new input is taken while the previous result still waits on m_tready.
// Reset (aresetn low, synchronous): table empty, active_slots = 16, no result.

module lru_client_address_table_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // [31:0] client_ip, [47:32] client_port, [79:48] now
    input  logic [79:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] slot, [5:4] outcome, [37:6] evicted_ip, [53:38] evicted_port, [55:54] zero
    output logic [55:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    localparam int IDX_W  = lcat_pkg::IDX_W;
    localparam int CNT_W  = lcat_pkg::CNT_W;

    logic [1:0]                        state_reg, state_next;
    logic [lcat_pkg::SLOTS_W-1:0]      active_slots_reg;
    logic [CNT_W-1:0]                  n_reg, n_calc;
    logic [CNT_W-1:0]                  rd_idx_reg;
    logic                              cmp_vld_reg;
    logic [IDX_W-1:0]                  cmp_idx_reg;
    logic [lcat_pkg::TABLE_DEPTH-1:0]  valid_reg;

    logic [lcat_pkg::IP_W-1:0]         key_ip_reg;
    logic [lcat_pkg::PORT_W-1:0]       key_port_reg;
    logic [lcat_pkg::TIME_W-1:0]       key_time_reg;

    logic                              have_match_reg, have_free_reg, have_old_reg;
    logic [IDX_W-1:0]                  match_idx_reg, free_idx_reg, old_idx_reg;
    lcat_pkg::entry_t                  old_entry_reg;

    logic [lcat_pkg::M_TDATA_W-1:0]    m_tdata_reg;
    logic                              m_tvalid_reg;

    logic                              s_fire, issue, cfg_wr, out_free, wb_go;
    logic [IDX_W-1:0]                  target;
    logic [lcat_pkg::OUTC_W-1:0]       outcome;
    logic [lcat_pkg::IP_W-1:0]         ev_ip;
    logic [lcat_pkg::PORT_W-1:0]       ev_port;
    lcat_pkg::entry_t                  rd_entry, wr_entry;
    lcat_pkg::cmp_res_t                cmp_res;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign issue    = (state_reg == ST_SCAN) && (rd_idx_reg < n_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign wb_go    = (state_reg == ST_WRITE) && out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == lcat_pkg::REG_ACTIVE_SLOTS);
    assign prdata = (paddr[2] == lcat_pkg::REG_ACTIVE_SLOTS) ?
                    {{(32 - lcat_pkg::SLOTS_W){1'b0}}, active_slots_reg} : 32'd0;

    always_comb begin
        if (active_slots_reg == '0) begin
            n_calc = CNT_W'(1);
        end else if (32'(active_slots_reg) > lcat_pkg::TABLE_DEPTH) begin
            n_calc = CNT_W'(lcat_pkg::TABLE_DEPTH);
        end else begin
            n_calc = CNT_W'(active_slots_reg);
        end
    end

    always_comb begin
        ev_ip   = '0;
        ev_port = '0;
        if (have_match_reg) begin
            target  = match_idx_reg;
            outcome = lcat_pkg::OUTC_REFRESH;
        end else if (have_free_reg) begin
            target  = free_idx_reg;
            outcome = lcat_pkg::OUTC_FILL;
        end else begin
            target  = old_idx_reg;
            outcome = lcat_pkg::OUTC_EVICT;
            ev_ip   = old_entry_reg.ip;
            ev_port = old_entry_reg.port;
        end
    end

    assign wr_entry.ip     = key_ip_reg;
    assign wr_entry.port   = key_port_reg;
    assign wr_entry.tstamp = key_time_reg;

    lcat_mem u_mem (
        .aclk  (aclk),
        .we    (wb_go),
        .waddr (target),
        .wdata (wr_entry),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    lcat_cmp u_cmp (
        .entry    (rd_entry),
        .key_ip   (key_ip_reg),
        .key_port (key_port_reg),
        .have_old (have_old_reg),
        .old_time (old_entry_reg.tstamp),
        .res      (cmp_res)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!issue && !cmp_vld_reg) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            active_slots_reg <= lcat_pkg::ACTIVE_SLOTS_RESET;
            valid_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
            cmp_vld_reg      <= 1'b0;
            rd_idx_reg       <= '0;
            n_reg            <= CNT_W'(1);
            have_match_reg   <= 1'b0;
            have_free_reg    <= 1'b0;
            have_old_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= issue;
            if (cfg_wr) begin
                active_slots_reg <= pwdata[lcat_pkg::SLOTS_W-1:0];
            end
            if (s_fire) begin
                n_reg          <= n_calc;
                rd_idx_reg     <= '0;
                have_match_reg <= 1'b0;
                have_free_reg  <= 1'b0;
                have_old_reg   <= 1'b0;
            end
            if (issue) begin
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            end
            if (cmp_vld_reg) begin
                if (!valid_reg[cmp_idx_reg]) begin
                    have_free_reg <= 1'b1;
                end else if (cmp_res.hit) begin
                    have_match_reg <= 1'b1;
                end else if (cmp_res.older) begin
                    have_old_reg <= 1'b1;
                end
            end
            if (wb_go) begin
                valid_reg[target] <= 1'b1;
                m_tvalid_reg      <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        if (s_fire) begin
            key_ip_reg   <= s_tdata[31:0];
            key_port_reg <= s_tdata[47:32];
            key_time_reg <= s_tdata[79:48];
        end
        if (cmp_vld_reg) begin
            if (!valid_reg[cmp_idx_reg]) begin
                free_idx_reg <= cmp_idx_reg;
            end else if (cmp_res.hit) begin
                if (!have_match_reg) begin
                    match_idx_reg <= cmp_idx_reg;
                end
            end else if (cmp_res.older) begin
                old_idx_reg   <= cmp_idx_reg;
                old_entry_reg <= rd_entry;
            end
        end
        if (wb_go) begin
            m_tdata_reg <= {2'b00, ev_port, ev_ip, outcome,
                            lcat_pkg::SLOT_W'(target)};
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

`ifndef SYNTHESIS
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (rd_idx_reg <= n_reg))
        else $error("scan index past active range");

    a_n_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |->
        (n_reg != '0) && (32'(n_reg) <= lcat_pkg::TABLE_DEPTH))
        else $error("active slot count out of range");

    a_outcome_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_go |-> (outcome == lcat_pkg::OUTC_REFRESH || outcome == lcat_pkg::OUTC_FILL ||
                   outcome == lcat_pkg::OUTC_EVICT))
        else $error("illegal outcome code");

    a_target_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_go |=> valid_reg[$past(target)] && m_tvalid_reg)
        else $error("written slot not marked valid");

    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (wb_go && outcome == lcat_pkg::OUTC_EVICT) |-> have_old_reg)
        else $error("eviction without a valid candidate");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lcat_pkg::*;

    localparam int          DRAIN_CYCLES   = 24;
    localparam int          DRAIN_LIMIT    = 5000;
    localparam int          RX_HOLD_CYCLES = 500;
    localparam int          POOL_MAX       = 24;
    localparam int          PHASES         = 10;
    localparam int          PHASE_ITEMS    = 70;
    localparam logic [2:0]  ADDR_ACTIVE_SLOTS = 3'(4 * REG_ACTIVE_SLOTS);
    localparam logic [2:0]  ADDR_UNMAPPED     = 3'd4;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [PORT_W-1:0] port;
        logic [IP_W-1:0]   ip;
    } client_beat_t;

    typedef struct packed {
        logic [PORT_W-1:0] ev_port;
        logic [IP_W-1:0]   ev_ip;
        logic [OUTC_W-1:0] outcome;
        logic [SLOT_W-1:0] slot;
    } lookup_result_t;

    localparam int RES_W = $bits(lookup_result_t);

    class lru_table_scoreboard;
        logic [SLOTS_W-1:0] active_slots;
        bit                 entry_valid[TABLE_DEPTH];
        logic [IP_W-1:0]    entry_ip[TABLE_DEPTH];
        logic [PORT_W-1:0]  entry_port[TABLE_DEPTH];
        logic [TIME_W-1:0]  entry_stamp[TABLE_DEPTH];
        lookup_result_t     pending_lookups[$];
        int                 fail_count;

        function new();
            active_slots = ACTIVE_SLOTS_RESET;
            fail_count = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                entry_valid[i] = 1'b0;
            end
        endfunction

        function int used_slots();
            if (active_slots == 0) return 1;
            if (active_slots > TABLE_DEPTH) return TABLE_DEPTH;
            return int'(active_slots);
        endfunction

        function int pending();
            return pending_lookups.size();
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            fail_count++;
            if (fail_count <= 10) begin
                $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
            end
        endfunction

        // accepted input beat: update the table copy and queue the lookup result
        function void record_client(client_beat_t beat);
            int             n;
            bit             have_free;
            bit             have_old;
            int             free_idx;
            int             old_idx;
            int             target;
            lookup_result_t r;
            n = used_slots();
            have_free = 1'b0;
            have_old = 1'b0;
            free_idx = 0;
            old_idx = 0;
            r = '0;
            for (int i = 0; i < n; i++) begin
                if (!entry_valid[i]) begin
                    have_free = 1'b1;
                    free_idx = i;
                end else if (entry_ip[i] == beat.ip && entry_port[i] == beat.port) begin
                    entry_stamp[i] = beat.stamp;
                    r.slot = SLOT_W'(i);
                    r.outcome = OUTC_REFRESH;
                    pending_lookups.push_back(r);
                    return;
                end else if (!have_old || entry_stamp[i] < entry_stamp[old_idx]) begin
                    have_old = 1'b1;
                    old_idx = i;
                end
            end
            if (have_free) begin
                target = free_idx;
                r.outcome = OUTC_FILL;
            end else begin
                target = old_idx;
                r.outcome = OUTC_EVICT;
                r.ev_ip = entry_ip[target];
                r.ev_port = entry_port[target];
            end
            r.slot = SLOT_W'(target);
            entry_valid[target] = 1'b1;
            entry_ip[target] = beat.ip;
            entry_port[target] = beat.port;
            entry_stamp[target] = beat.stamp;
            pending_lookups.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            lookup_result_t want;
            lookup_result_t got;
            if (pending_lookups.size() == 0) begin
                flag("result beat with no lookup pending", '0, beat);
                return;
            end
            want = pending_lookups.pop_front();
            got = beat[RES_W-1:0];
            if (got.slot !== want.slot) flag("slot", want.slot, got.slot);
            if (got.outcome !== want.outcome) flag("outcome", want.outcome, got.outcome);
            if (got.ev_ip !== want.ev_ip) flag("evicted_ip", want.ev_ip, got.ev_ip);
            if (got.ev_port !== want.ev_port) flag("evicted_port", want.ev_port, got.ev_port);
            if (beat[M_TDATA_W-1:RES_W] !== '0) flag("m_tdata pad", '0, beat[M_TDATA_W-1:RES_W]);
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [2:0]           paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    lru_table_scoreboard sb = new();

    int unsigned       tx_gap_rate = 0;
    bit                rx_idle_on  = 1'b0;
    bit                rx_hold     = 1'b0;
    logic [TIME_W-1:0] sim_seconds = '0;
    logic [IP_W-1:0]   pool_ip[POOL_MAX];
    logic [PORT_W-1:0] pool_port[POOL_MAX];

    lru_client_address_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (s_tvalid && s_tready) sb.record_client(s_tdata);
        end
    end

    // result side: random stall bursts, plus one long hold on request
    initial begin : ready_driver
        int unsigned stall;
        forever begin
            @(posedge aclk);
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
                rx_hold = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 14);
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_client(input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port,
                               input logic [TIME_W-1:0] stamp);
        client_beat_t beat;
        int unsigned  gap;
        beat.ip = ip;
        beat.port = port;
        beat.stamp = stamp;
        s_tdata <= beat;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (tx_gap_rate != 0 && $urandom_range(0, 3) < tx_gap_rate) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_table();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_ACTIVE_SLOTS) sb.active_slots = data[SLOTS_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) sb.flag("active_slots readback", want, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // upper pwdata bits are junk on purpose, only the low five bits land
    task automatic configure_slots(input logic [SLOTS_W-1:0] slots);
        logic [31:0] data;
        drain_table();
        data = $urandom();
        data[SLOTS_W-1:0] = slots;
        apb_write(ADDR_ACTIVE_SLOTS, data);
        apb_read_check(ADDR_ACTIVE_SLOTS, 32'(slots));
    endtask

    task automatic send_random(input int pool_n);
        int                k;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] stamp;
        if ($urandom_range(0, 99) < 85) begin
            k = $urandom_range(0, pool_n - 1);
            ip = pool_ip[k];
            port = pool_port[k];
        end else begin
            ip = $urandom();
            port = PORT_W'($urandom());
        end
        if ($urandom_range(0, 9) == 0) begin
            stamp = $urandom();
        end else begin
            sim_seconds += $urandom_range(0, 3);
            stamp = sim_seconds;
        end
        send_client(ip, port, stamp);
    endtask

    initial begin : stimulus
        logic [SLOTS_W-1:0] phase_slots[PHASES];
        int                 pool_n;
        phase_slots = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd8, 5'd2, 5'd17, 5'd12, 5'd16};
        phase_slots[6] = SLOTS_W'($urandom_range(0, 31));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        apb_read_check(ADDR_ACTIVE_SLOTS, 32'(ACTIVE_SLOTS_RESET));
        // full table after reset: fill from the top, refresh, near-miss keys
        send_client('0, '0, '0);
        send_client('1, '1, '1);
        send_client('0, '0, 32'd7);
        send_client('1, '0, 32'd1);
        send_client('0, '1, 32'd2);
        // zero slots behaves as one
        configure_slots(5'd0);
        send_client(32'hA5A5_A5A5, 16'h1234, 32'd10);
        send_client(32'h5A5A_5A5A, 16'h4321, 32'd11);
        send_client(32'h5A5A_5A5A, 16'h4321, 32'd12);
        // two slots: stamp tie goes to the lower slot, compare is unsigned
        configure_slots(5'd2);
        send_client(32'd1, 16'd1, 32'd12);
        send_client(32'd2, 16'd2, 32'd30);
        send_client(32'd3, 16'd3, 32'hFFFF_FFFF);
        send_client(32'd4, 16'd4, 32'd0);
        // oversize count clamps; entries parked above the range come back
        configure_slots(5'd31);
        send_client('1, '1, 32'd5);
        send_client(32'h8000_0000, 16'h8000, 32'h8000_0000);
        drain_table();
        apb_write(ADDR_UNMAPPED, 32'h1);
        apb_read_check(ADDR_ACTIVE_SLOTS, 32'd31);
        send_client(32'd7, 16'd7, 32'd9);
        send_client(32'd4, 16'd4, 32'd9);

        for (int p = 0; p < PHASES; p++) begin
            configure_slots(phase_slots[p]);
            tx_gap_rate = $urandom_range(0, 3);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (p == PHASES - 1) begin
                tx_gap_rate = 0;
                rx_idle_on = 1'b0;
            end
            pool_n = sb.used_slots() + $urandom_range(0, 6);
            for (int i = 0; i < POOL_MAX; i++) begin
                pool_ip[i] = (i > 0 && $urandom_range(0, 3) == 0) ? pool_ip[i-1] : $urandom();
                pool_port[i] = PORT_W'($urandom());
            end
            if ($urandom_range(0, 2) == 0) sim_seconds = $urandom();
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                if (p == 2 && j == 10) begin
                    rx_hold = 1'b1;
                    tx_gap_rate = 0;
                end
                if (p == 2 && j == 40) tx_gap_rate = 2;
                if (p == 5 && j == 35) drain_table();
                send_random(pool_n);
            end
        end

        drain_table();
        if (sb.pending() != 0) sb.flag("lookups left without a result", '0, sb.pending());
        if (sb.fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/lcat_pkg.sv
sv/lcat_mem.sv
sv/lcat_cmp.sv
sv/lru_client_address_table_unit.sv
dv/testbench.sv
